FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the colour converter
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// consequent holds a fixed number of cycles after the antecedent
`define ASSERT_AFTER(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("assertion failed: delayed implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_AFTER(lbl, clk, rst, ante, n, cons)
`endif
`endif

FILE: hw/rtl/y2r_pkg.sv
// constants and widths for the yuyv to rgb888 colour converter
// no dependencies; used by y2r_finish and the top level
`default_nettype none

package y2r_pkg;

   // field widths
   localparam int PIX_W  = 8;
   localparam int FRAC_W = 16;

   // signed chroma offset, one bit wider than a byte
   localparam int DIFF_W = PIX_W + 1;

   // coefficient products and channel sums in q16
   localparam int COEF_W = 18;
   localparam int PROD_W = 25;
   localparam int SUM_W  = 26;

   // q16 coefficients, rounded to nearest
   localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd89831;
   localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd45744;
   localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22127;
   localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd113538;

   // chroma zero point
   localparam logic signed [DIFF_W-1:0] CHROMA_MID = 9'sd128;

   // output scaling: (c * 220) >> 8
   localparam int SCALE_W = 8;
   localparam logic [SCALE_W-1:0] SCALE_MUL = 8'd220;
   localparam logic [PIX_W-1:0]   LEVEL_MAX = 8'd219;

   // channel slots in the sum array
   localparam int CH_NUM       = 6;
   localparam int CH_RED_1ST   = 0;
   localparam int CH_GREEN_1ST = 1;
   localparam int CH_BLUE_1ST  = 2;
   localparam int CH_RED_2ND   = 3;
   localparam int CH_GREEN_2ND = 4;
   localparam int CH_BLUE_2ND  = 5;

endpackage

`default_nettype wire

FILE: hw/rtl/y2r_finish.sv
// last two pipeline stages of one colour channel: clamp, then 220/256 scale
// depends on y2r_pkg
`default_nettype none

module y2r_finish
   import y2r_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic signed [SUM_W-1:0] sum_i,
   output logic        [PIX_W-1:0]      level_o
);

   logic [PIX_W-1:0]         clamp_in;
   logic [PIX_W-1:0]         clamp_ff;
   logic [PIX_W+SCALE_W-1:0] scaled_in;
   logic [PIX_W-1:0]         level_ff;

   // truncate toward zero and clamp: any negative sum ends at zero,
   // anything at or above 256.0 saturates
   always_comb begin
      if (sum_i[SUM_W-1]) begin
         clamp_in = '0;
      end else if (|sum_i[SUM_W-2:FRAC_W+PIX_W]) begin
         clamp_in = '1;
      end else begin
         clamp_in = sum_i[FRAC_W+PIX_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      clamp_ff <= clamp_in;
   end

   // scale by 220/256
   assign scaled_in = (PIX_W+SCALE_W)'(clamp_ff) * (PIX_W+SCALE_W)'(SCALE_MUL);

   always_ff @(posedge clock) begin
      level_ff <= scaled_in[PIX_W+SCALE_W-1:SCALE_W];
   end

   assign level_o = level_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/yuyv_to_rgb888_converter_unit.sv
// Colour converter: one packed YUYV 4:2:2 word in, two RGB888 pixels out.
//
// Request channel: drive req_* and raise start; the request is taken at
// each rising edge where start is high and busy is low. busy stays low,
// so a new word may be offered in every cycle.
// Result channel: rsp_valid is high for exactly one cycle with the two
// pixels and the passed-through end-of-frame mark on the rsp_* ports.
// The receiver must take the result in that cycle; it cannot stall.
//
// Each word passes through the four-stage pipeline (chroma products, channel
// sums, clamp, 220/256 scale). Throughput: one word per cycle.
// Order is kept; every request gives exactly one result.
//
// Reset (synchronous, active high) clears the valid pipeline, so no result
// appears from words in flight at reset. No other state is held.
//
// depends on y2r_pkg, y2r_finish and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module yuyv_to_rgb888_converter_unit
   import y2r_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [PIX_W-1:0] req_luma_first,
   input  wire logic [PIX_W-1:0] req_chroma_blue,
   input  wire logic [PIX_W-1:0] req_luma_second,
   input  wire logic [PIX_W-1:0] req_chroma_red,
   input  wire logic             req_frame_end,
   // result channel
   output logic                  rsp_valid,
   output logic      [PIX_W-1:0] rsp_red_first,
   output logic      [PIX_W-1:0] rsp_green_first,
   output logic      [PIX_W-1:0] rsp_blue_first,
   output logic      [PIX_W-1:0] rsp_red_second,
   output logic      [PIX_W-1:0] rsp_green_second,
   output logic      [PIX_W-1:0] rsp_blue_second,
   output logic                  rsp_frame_end_out
);

   logic accept;

   // stage 1: chroma offsets and coefficient products
   logic signed [DIFF_W-1:0] du_s;
   logic signed [DIFF_W-1:0] dv_s;
   logic signed [PROD_W-1:0] prod_rv_in, prod_gv_in, prod_gu_in, prod_bu_in;
   logic signed [PROD_W-1:0] prod_rv_ff, prod_gv_ff, prod_gu_ff, prod_bu_ff;
   logic        [PIX_W-1:0]  luma_first_ff, luma_second_ff;
   logic                     s1_valid_ff, s1_end_ff;

   // stage 2: channel sums
   logic signed [SUM_W-1:0]  base_first, base_second;
   logic signed [SUM_W-1:0]  sum_in [CH_NUM];
   logic signed [SUM_W-1:0]  sum_ff [CH_NUM];
   logic                     s2_valid_ff, s2_end_ff;

   // stages 3 and 4 live in the channel finishers
   logic        [PIX_W-1:0]  level [CH_NUM];
   logic                     s3_valid_ff, s3_end_ff;
   logic                     rsp_valid_ff, rsp_end_ff;

   // range check on the result levels
   logic                     levels_in_range;

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // chroma offsets and products
   assign du_s = $signed({1'b0, req_chroma_blue}) - CHROMA_MID;
   assign dv_s = $signed({1'b0, req_chroma_red}) - CHROMA_MID;

   assign prod_rv_in = PROD_W'(dv_s) * PROD_W'(COEF_RV);
   assign prod_gv_in = PROD_W'(dv_s) * PROD_W'(COEF_GV);
   assign prod_gu_in = PROD_W'(du_s) * PROD_W'(COEF_GU);
   assign prod_bu_in = PROD_W'(du_s) * PROD_W'(COEF_BU);

   always_ff @(posedge clock) begin
      prod_rv_ff     <= prod_rv_in;
      prod_gv_ff     <= prod_gv_in;
      prod_gu_ff     <= prod_gu_in;
      prod_bu_ff     <= prod_bu_in;
      luma_first_ff  <= req_luma_first;
      luma_second_ff <= req_luma_second;
      s1_end_ff      <= req_frame_end;
   end

   // luma in q16 plus the shared chroma terms
   assign base_first  = $signed(SUM_W'({luma_first_ff, {FRAC_W{1'b0}}}));
   assign base_second = $signed(SUM_W'({luma_second_ff, {FRAC_W{1'b0}}}));

   always_comb begin
      sum_in[CH_RED_1ST]   = base_first + SUM_W'(prod_rv_ff);
      sum_in[CH_GREEN_1ST] = base_first - SUM_W'(prod_gv_ff) - SUM_W'(prod_gu_ff);
      sum_in[CH_BLUE_1ST]  = base_first + SUM_W'(prod_bu_ff);
      sum_in[CH_RED_2ND]   = base_second + SUM_W'(prod_rv_ff);
      sum_in[CH_GREEN_2ND] = base_second - SUM_W'(prod_gv_ff) - SUM_W'(prod_gu_ff);
      sum_in[CH_BLUE_2ND]  = base_second + SUM_W'(prod_bu_ff);
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      s2_end_ff <= s1_end_ff;
   end

   // clamp and scale, one finisher per channel
   for (genvar ch = 0; ch < CH_NUM; ch++) begin : g_finish
      y2r_finish u_finish (
         .clock   (clock),
         .sum_i   (sum_ff[ch]),
         .level_o (level[ch])
      );
   end

   // end-of-frame mark alongside the finisher stages
   always_ff @(posedge clock) begin
      s3_end_ff  <= s2_end_ff;
      rsp_end_ff <= s3_end_ff;
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_end_out = rsp_end_ff;
   assign rsp_red_first     = level[CH_RED_1ST];
   assign rsp_green_first   = level[CH_GREEN_1ST];
   assign rsp_blue_first    = level[CH_BLUE_1ST];
   assign rsp_red_second    = level[CH_RED_2ND];
   assign rsp_green_second  = level[CH_GREEN_2ND];
   assign rsp_blue_second   = level[CH_BLUE_2ND];

   // all six levels at or below the top of the scaled range
   assign levels_in_range = rsp_red_first <= LEVEL_MAX && rsp_green_first <= LEVEL_MAX &&
                            rsp_blue_first <= LEVEL_MAX && rsp_red_second <= LEVEL_MAX &&
                            rsp_green_second <= LEVEL_MAX && rsp_blue_second <= LEVEL_MAX;

   // every accepted request gives a result
   `ASSERT_AFTER(a_req_gives_rsp, clock, reset, accept, 4, rsp_valid)
   // no result without an earlier accepted request
   `ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_valid, $past(accept, 4))
   // the end-of-frame mark stays with its word
   `ASSERT_IMPLIES(a_end_kept, clock, reset, rsp_valid, rsp_frame_end_out == $past(req_frame_end, 4))
   // scaled levels never pass the top of the range
   `ASSERT_IMPLIES(a_level_range, clock, reset, rsp_valid, levels_in_range)

endmodule

`default_nettype wire
